@@ design/marching_squares_cell_defines.svh @@
// Assertion helpers for the marching squares cell block.
// Both expect clk and rst_n in scope.
`ifndef MARCHING_SQUARES_CELL_DEFINES_SVH
`define MARCHING_SQUARES_CELL_DEFINES_SVH
`ifndef SYNTHESIS
`define MSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MSC_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define MSC_ASSERT(lbl, prop, msg)
`define MSC_NEVER(lbl, expr, msg)
`endif
`endif

@@ design/msc_pkg.sv @@
package msc_pkg;

  localparam int SAMPLE_BITS_DEF = 16;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Y   = 3'd4;

  localparam int EXT_W   = 13;
  localparam int CELLS_W = 9;
  localparam int IDX_W   = 8;
  localparam int COORD_W = 12;
  localparam int CODE_W  = 4;
  // quotient bits of every coordinate divide; a term never reaches 2^14
  localparam int QUO_W   = 14;
  localparam int BASE_NW = IDX_W + EXT_W;

  localparam logic [EXT_W-1:0]   WIDTH_RST   = 13'd640;
  localparam logic [EXT_W-1:0]   HEIGHT_RST  = 13'd480;
  localparam logic [CELLS_W-1:0] CELLS_X_RST = 9'd64;
  localparam logic [CELLS_W-1:0] CELLS_Y_RST = 9'd48;

  localparam int MAX_IMAGE   = 4096;
  localparam int COORD_LIMIT = 4095;
  localparam int LIM_CAP = (MAX_IMAGE < COORD_LIMIT + 1) ? MAX_IMAGE : COORD_LIMIT + 1;

  localparam logic [CODE_W-1:0] CODE_NONE = 4'd0;
  localparam logic [CODE_W-1:0] CODE_ALL  = 4'd15;

  typedef logic [1:0] edge_t;
  localparam edge_t EDGE_L = 2'd0;
  localparam edge_t EDGE_T = 2'd1;
  localparam edge_t EDGE_R = 2'd2;
  localparam edge_t EDGE_B = 2'd3;

  localparam edge_t EDGE_FIRST [16] = '{
    EDGE_L, EDGE_L, EDGE_T, EDGE_L, EDGE_R, EDGE_B, EDGE_B, EDGE_B,
    EDGE_B, EDGE_B, EDGE_B, EDGE_B, EDGE_L, EDGE_T, EDGE_T, EDGE_L};
  localparam edge_t EDGE_SECOND [16] = '{
    EDGE_L, EDGE_T, EDGE_R, EDGE_R, EDGE_B, EDGE_L, EDGE_T, EDGE_L,
    EDGE_L, EDGE_T, EDGE_R, EDGE_R, EDGE_R, EDGE_R, EDGE_L, EDGE_L};

  typedef struct packed {
    logic              vld;
    logic [CODE_W-1:0] code;
    logic [IDX_W-1:0]  col;
    logic [IDX_W-1:0]  row;
  } msc_ctl_t;

endpackage

@@ design/msc_stream_if.sv @@
interface msc_in_if import msc_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic [IDX_W-1:0]              cell_col;
  logic [IDX_W-1:0]              cell_row;
  logic signed [SAMPLE_BITS-1:0] value_left_top;
  logic signed [SAMPLE_BITS-1:0] value_left_bottom;
  logic signed [SAMPLE_BITS-1:0] value_right_top;
  logic signed [SAMPLE_BITS-1:0] value_right_bottom;

  modport source (output valid, cell_col, cell_row, value_left_top, value_left_bottom,
                  value_right_top, value_right_bottom, input ready);
  modport sink   (input valid, cell_col, cell_row, value_left_top, value_left_bottom,
                  value_right_top, value_right_bottom, output ready);
endinterface

interface msc_out_if import msc_pkg::*;;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] start_x;
  logic [COORD_W-1:0] start_y;
  logic [COORD_W-1:0] end_x;
  logic [COORD_W-1:0] end_y;
  logic [CODE_W-1:0]  case_code;

  modport source (output valid, start_x, start_y, end_x, end_y, case_code, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, case_code, output ready);
endinterface

@@ design/msc_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// Quotient saturates to all ones when it would not fit in QB bits.
module msc_div import msc_pkg::*; #(
  parameter int NW = 31,
  parameter int DW = 26,
  parameter int QB = QUO_W
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QB-1:0] quo
);
  localparam int CW = NW + DW + QB;

  logic [NW-1:0] rem_r [QB-1];
  logic [DW-1:0] den_r [QB-1];
  logic [QB-1:0] q_r   [QB];
  logic          ovf_r [QB];

  for (genvar s = 0; s < QB; s++) begin : g_stage
    logic [NW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QB-1:0] q_in;
    logic          ovf_in;
    logic [CW-1:0] dsh;
    logic          take;

    if (s == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign q_in   = '0;
      assign ovf_in = CW'(num) >= (CW'(den) << QB);
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign den_in = den_r[s-1];
      assign q_in   = q_r[s-1];
      assign ovf_in = ovf_r[s-1];
    end

    assign dsh  = CW'(den_in) << (QB - 1 - s);
    assign take = CW'(rem_in) >= dsh;

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[s]   <= q_in | (take ? (QB'(1) << (QB - 1 - s)) : '0);
        ovf_r[s] <= ovf_in;
      end
    end

    if (s < QB - 1) begin : g_keep
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s] <= take ? NW'(CW'(rem_in) - dsh) : rem_in;
          den_r[s] <= den_in;
        end
      end
    end
  end

  assign quo = ovf_r[QB-1] ? '1 : q_r[QB-1];

endmodule

@@ design/msc_front.sv @@
// Input register, corner classification and edge fractions (three stages).
module msc_front import msc_pkg::*; #(
  parameter int SB = SAMPLE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  msc_in_if.sink               in_if,
  input  logic signed [SB-1:0] thr,
  input  logic [CELLS_W-1:0]   cells_x,
  input  logic [CELLS_W-1:0]   cells_y,
  output msc_ctl_t             ctl,
  output logic [SB-1:0]        frac_n [4],
  output logic [SB-1:0]        frac_d [4]
);

  function automatic logic [2*SB-1:0] make_frac(input logic signed [SB-1:0] t,
                                                input logic signed [SB-1:0] a,
                                                input logic signed [SB-1:0] b);
    logic signed [SB:0] n;
    logic signed [SB:0] d;
    logic [SB-1:0]      nu;
    logic [SB-1:0]      du;
    n = (SB+1)'(t) - (SB+1)'(a);
    d = (SB+1)'(b) - (SB+1)'(a);
    if (d == 0) begin
      nu = '0;
      du = SB'(1);
    end else begin
      if (d < 0) begin
        n = -n;
        d = -d;
      end
      if (n < 0) nu = '0;
      else if (n > d) nu = d[SB-1:0];
      else nu = n[SB-1:0];
      du = d[SB-1:0];
    end
    return {nu, du};
  endfunction

  assign in_if.ready = en;

  // stage 1: input word
  logic                 v1_r;
  logic [IDX_W-1:0]     col1_r, row1_r;
  logic signed [SB-1:0] lt1_r, lb1_r, rt1_r, rb1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_if.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      col1_r <= in_if.cell_col;
      row1_r <= in_if.cell_row;
      lt1_r  <= in_if.value_left_top;
      lb1_r  <= in_if.value_left_bottom;
      rt1_r  <= in_if.value_right_top;
      rb1_r  <= in_if.value_right_bottom;
    end
  end

  // stage 2: corners past the edge take the threshold, then the case code
  logic                 right_out, bottom_out;
  logic signed [SB-1:0] lb_a, rt_a, rb_a;
  logic [CODE_W-1:0]    code_nxt;

  assign right_out  = (CELLS_W'(col1_r) + CELLS_W'(1)) >= cells_x;
  assign bottom_out = (CELLS_W'(row1_r) + CELLS_W'(1)) >= cells_y;
  assign lb_a = bottom_out ? thr : lb1_r;
  assign rt_a = right_out ? thr : rt1_r;
  assign rb_a = (right_out || bottom_out) ? thr : rb1_r;
  assign code_nxt = {lb_a > thr, rb_a > thr, rt_a > thr, lt1_r > thr};

  logic                 v2_r;
  logic [CODE_W-1:0]    code2_r;
  logic [IDX_W-1:0]     col2_r, row2_r;
  logic signed [SB-1:0] lt2_r, lb2_r, rt2_r, rb2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r && (code_nxt != CODE_NONE) && (code_nxt != CODE_ALL);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      code2_r <= code_nxt;
      col2_r  <= col1_r;
      row2_r  <= row1_r;
      lt2_r   <= lt1_r;
      lb2_r   <= lb_a;
      rt2_r   <= rt_a;
      rb2_r   <= rb_a;
    end
  end

  // stage 3: crossing fractions on the left, top, right and bottom edges
  logic [2*SB-1:0] f_nxt [4];
  assign f_nxt[EDGE_L] = make_frac(thr, lt2_r, lb2_r);
  assign f_nxt[EDGE_T] = make_frac(thr, lt2_r, rt2_r);
  assign f_nxt[EDGE_R] = make_frac(thr, rt2_r, rb2_r);
  assign f_nxt[EDGE_B] = make_frac(thr, lb2_r, rb2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) ctl.vld <= 1'b0;
    else if (en) ctl.vld <= v2_r;
    if (en) begin
      ctl.code <= code2_r;
      ctl.col  <= col2_r;
      ctl.row  <= row2_r;
      for (int k = 0; k < 4; k++) begin
        frac_n[k] <= f_nxt[k][2*SB-1:SB];
        frac_d[k] <= f_nxt[k][SB-1:0];
      end
    end
  end

endmodule

@@ design/marching_squares_cell.sv @@
// Marching squares cell: one grid cell word in (column, row, four corner
// samples), at most one isoline segment word out in pixel coordinates plus
// its 4-bit case code; uniform cells (code 0 or 15) give no word. The block
// takes one cell per clock while the output is not stalled, through three
// front stages, edge selection, one multiply stage, a 14-stage pipelined
// restoring divider per coordinate and an output register. Throughput is one word
// per cycle unless the output is stalled, set by the fully pipelined dividers. A
// stalled output freezes the whole pipeline; nothing is dropped or repeated.
// Configuration registers are written through cfg_we/cfg_idx/cfg_wdata while the
// pipeline is empty, a rule for the user that the block does not enforce; a zero
// size register is stored as 1. There is no memory and no clearing pass after reset.
`include "marching_squares_cell_defines.svh"

module marching_squares_cell import msc_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [((SAMPLE_BITS > EXT_W) ? SAMPLE_BITS : EXT_W)-1:0] cfg_wdata,
  msc_in_if.sink               in_if,
  msc_out_if.source            out_if
);
  localparam int SB  = SAMPLE_BITS;
  localparam int FNW = SB + 2 + EXT_W;   // w * (2n + d)
  localparam int FDW = SB + 1 + CELLS_W; // 2 * cells * d
  localparam int SW  = QUO_W + 1;        // base + term

  // ---------------- configuration ----------------
  logic signed [SB-1:0] thr_r;
  logic [EXT_W-1:0]     w_r, h_r;
  logic [CELLS_W-1:0]   cx_r, cy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
      w_r   <= WIDTH_RST;
      h_r   <= HEIGHT_RST;
      cx_r  <= CELLS_X_RST;
      cy_r  <= CELLS_Y_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_THRESHOLD: thr_r <= cfg_wdata[SB-1:0];
        CFG_WIDTH: w_r <= (cfg_wdata[EXT_W-1:0] == '0) ? EXT_W'(1) : cfg_wdata[EXT_W-1:0];
        CFG_HEIGHT: h_r <= (cfg_wdata[EXT_W-1:0] == '0) ? EXT_W'(1) : cfg_wdata[EXT_W-1:0];
        CFG_CELLS_X:
          cx_r <= (cfg_wdata[CELLS_W-1:0] == '0) ? CELLS_W'(1) : cfg_wdata[CELLS_W-1:0];
        CFG_CELLS_Y:
          cy_r <= (cfg_wdata[CELLS_W-1:0] == '0) ? CELLS_W'(1) : cfg_wdata[CELLS_W-1:0];
        default: ;
      endcase
    end
  end

  // saturation limits: min(extent, cap) - 1
  logic [COORD_W-1:0] limx_r, limy_r;
  always_ff @(posedge clk) begin
    limx_r <= COORD_W'(((w_r > EXT_W'(LIM_CAP)) ? EXT_W'(LIM_CAP) : w_r) - EXT_W'(1));
    limy_r <= COORD_W'(((h_r > EXT_W'(LIM_CAP)) ? EXT_W'(LIM_CAP) : h_r) - EXT_W'(1));
  end

  // whole pipeline moves unless the output word is held
  logic out_vld_r;
  logic en;
  assign en = !out_vld_r || out_if.ready;

  // ---------------- stages 1-3 ----------------
  msc_ctl_t      ctl3;
  logic [SB-1:0] fn3 [4];
  logic [SB-1:0] fd3 [4];

  msc_front #(.SB(SB)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_if  (in_if),
    .thr    (thr_r),
    .cells_x(cx_r),
    .cells_y(cy_r),
    .ctl    (ctl3),
    .frac_n (fn3),
    .frac_d (fd3)
  );

  // ---------------- stage 4: pick the two crossing points ----------------
  // x is 0 on the left edge, 1 on the right; y is 0 on top, 1 at bottom.
  edge_t         sel [2];
  logic [SB-1:0] xn_nxt [2], xd_nxt [2], yn_nxt [2], yd_nxt [2];

  assign sel[0] = EDGE_FIRST[ctl3.code];
  assign sel[1] = EDGE_SECOND[ctl3.code];

  always_comb begin
    for (int p = 0; p < 2; p++) begin
      case (sel[p])
        EDGE_L: begin
          xn_nxt[p] = '0;          xd_nxt[p] = SB'(1);
          yn_nxt[p] = fn3[EDGE_L]; yd_nxt[p] = fd3[EDGE_L];
        end
        EDGE_T: begin
          xn_nxt[p] = fn3[EDGE_T]; xd_nxt[p] = fd3[EDGE_T];
          yn_nxt[p] = '0;          yd_nxt[p] = SB'(1);
        end
        EDGE_R: begin
          xn_nxt[p] = SB'(1);      xd_nxt[p] = SB'(1);
          yn_nxt[p] = fn3[EDGE_R]; yd_nxt[p] = fd3[EDGE_R];
        end
        default: begin
          xn_nxt[p] = fn3[EDGE_B]; xd_nxt[p] = fd3[EDGE_B];
          yn_nxt[p] = SB'(1);      yd_nxt[p] = SB'(1);
        end
      endcase
    end
  end

  msc_ctl_t      ctl4_r;
  logic [SB-1:0] xn4_r [2], xd4_r [2], yn4_r [2], yd4_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) ctl4_r.vld <= 1'b0;
    else if (en) ctl4_r.vld <= ctl3.vld;
    if (en) begin
      ctl4_r.code <= ctl3.code;
      ctl4_r.col  <= ctl3.col;
      ctl4_r.row  <= ctl3.row;
      xn4_r <= xn_nxt;
      xd4_r <= xd_nxt;
      yn4_r <= yn_nxt;
      yd4_r <= yd_nxt;
    end
  end

  // ---------------- stage 5: numerators and denominators ----------------
  // term = floor(ext * (2n + d) / (2 * cells * d)), base = floor(idx * ext / cells)
  logic             v5_r;
  logic [CODE_W-1:0] code5_r;
  logic [FNW-1:0]   nx5_r [2], ny5_r [2];
  logic [FDW-1:0]   dx5_r [2], dy5_r [2];
  logic [BASE_NW-1:0] bnx5_r, bny5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (en) v5_r <= ctl4_r.vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      code5_r <= ctl4_r.code;
      for (int p = 0; p < 2; p++) begin
        nx5_r[p] <= FNW'(w_r) * FNW'((FNW'(xn4_r[p]) << 1) + FNW'(xd4_r[p]));
        ny5_r[p] <= FNW'(h_r) * FNW'((FNW'(yn4_r[p]) << 1) + FNW'(yd4_r[p]));
        dx5_r[p] <= (FDW'(cx_r) * FDW'(xd4_r[p])) << 1;
        dy5_r[p] <= (FDW'(cy_r) * FDW'(yd4_r[p])) << 1;
      end
      bnx5_r <= BASE_NW'(ctl4_r.col) * BASE_NW'(w_r);
      bny5_r <= BASE_NW'(ctl4_r.row) * BASE_NW'(h_r);
    end
  end

  // ---------------- dividers ----------------
  logic [QUO_W-1:0] qx [2], qy [2];
  logic [QUO_W-1:0] bqx, bqy;

  for (genvar p = 0; p < 2; p++) begin : g_pt
    msc_div #(.NW(FNW), .DW(FDW), .QB(QUO_W)) u_div_x (
      .clk(clk), .en(en), .num(nx5_r[p]), .den(dx5_r[p]), .quo(qx[p]));
    msc_div #(.NW(FNW), .DW(FDW), .QB(QUO_W)) u_div_y (
      .clk(clk), .en(en), .num(ny5_r[p]), .den(dy5_r[p]), .quo(qy[p]));
  end

  msc_div #(.NW(BASE_NW), .DW(CELLS_W), .QB(QUO_W)) u_base_x (
    .clk(clk), .en(en), .num(bnx5_r), .den(cx_r), .quo(bqx));
  msc_div #(.NW(BASE_NW), .DW(CELLS_W), .QB(QUO_W)) u_base_y (
    .clk(clk), .en(en), .num(bny5_r), .den(cy_r), .quo(bqy));

  // valid and case code ride alongside the divider stages
  logic              vd_r    [QUO_W];
  logic [CODE_W-1:0] coded_r [QUO_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < QUO_W; s++) vd_r[s] <= 1'b0;
    end else if (en) begin
      vd_r[0] <= v5_r;
      for (int s = 1; s < QUO_W; s++) vd_r[s] <= vd_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      coded_r[0] <= code5_r;
      for (int s = 1; s < QUO_W; s++) coded_r[s] <= coded_r[s-1];
    end
  end

  // ---------------- output stage: add and saturate ----------------
  logic [SW-1:0]      sx [2], sy [2];
  logic [COORD_W-1:0] cx_nxt [2], cy_nxt [2];

  always_comb begin
    for (int p = 0; p < 2; p++) begin
      sx[p] = SW'(bqx) + SW'(qx[p]);
      sy[p] = SW'(bqy) + SW'(qy[p]);
      cx_nxt[p] = (sx[p] > SW'(limx_r)) ? limx_r : sx[p][COORD_W-1:0];
      cy_nxt[p] = (sy[p] > SW'(limy_r)) ? limy_r : sy[p][COORD_W-1:0];
    end
  end

  logic [COORD_W-1:0] sx_r, sy_r, ex_r, ey_r;
  logic [CODE_W-1:0]  code_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (en) out_vld_r <= vd_r[QUO_W-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx_r   <= cx_nxt[0];
      sy_r   <= cy_nxt[0];
      ex_r   <= cx_nxt[1];
      ey_r   <= cy_nxt[1];
      code_r <= coded_r[QUO_W-1];
    end
  end

  assign out_if.valid     = out_vld_r;
  assign out_if.start_x   = sx_r;
  assign out_if.start_y   = sy_r;
  assign out_if.end_x     = ex_r;
  assign out_if.end_y     = ey_r;
  assign out_if.case_code = code_r;

  // ---------------- checks ----------------
  `MSC_NEVER(a_no_uniform_out,
             out_vld_r && (code_r == CODE_NONE || code_r == CODE_ALL),
             "uniform cell reached output")
  `MSC_ASSERT(a_stall_keeps_word, !en |=> out_vld_r, "held output word lost")
  `MSC_ASSERT(a_rise_needs_advance, $rose(out_vld_r) |-> $past(en), "output word appeared while stalled")

endmodule
